@@ hw/rtl/fwdp_pkg.sv @@
// shared constants and types for the fixed width decimal parser
// no dependencies
`timescale 1ns / 1ps

package fwdp_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned VALUE_W    = 31;
  localparam int unsigned MAG_W      = 30;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned TDATA_IN_W = 8;
  localparam int unsigned TDATA_OUT_W = 32;

  localparam logic [POS_W-1:0] MAX_DIGITS = POS_W'(9);
  localparam logic [POS_W-1:0] POS_MAX    = '1;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE = 1'b1;

  localparam logic signed [VALUE_W-1:0] MIN_VALUE_RESET = -31'sd999999999;
  localparam logic signed [VALUE_W-1:0] MAX_VALUE_RESET = 31'sd999999999;

  // summary of one finished field
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             err;
  } field_t;

endpackage

@@ hw/rtl/fwdp_digit_acc.sv @@
// per-byte field state: sign, digit accumulation, position and error tracking
// registers the finished field summary; depends on fwdp_pkg
`timescale 1ns / 1ps

module fwdp_digit_acc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [fwdp_pkg::CHAR_W-1:0]   char_i,
  input  logic                          last_i,
  output logic                          fld_valid_o,
  input  logic                          fld_ready_i,
  output fwdp_pkg::field_t              fld_o
);
  import fwdp_pkg::*;

  logic [MAG_W-1:0]   acc_q, acc_d, acc_n, acc_x10;
  logic               neg_q, neg_d, neg_n;
  logic               err_q, err_d, err_n;
  logic [POS_W-1:0]   pos_q, pos_d, pos_n, digits;
  logic [CHAR_W-1:0]  char_off;
  logic [DIGIT_W-1:0] digit;
  logic               is_minus, is_digit, fire;
  logic               fld_valid_q, fld_valid_d;
  field_t             fld_q, fld_d;

  assign ready_o = !last_i || !fld_valid_q || fld_ready_i;
  assign fire    = valid_i && ready_o;

  assign is_minus = (pos_q == '0) && (char_i == CHAR_MINUS);
  assign is_digit = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
  assign char_off = char_i - CHAR_ZERO;
  assign digit    = char_off[DIGIT_W-1:0];
  assign digits   = pos_q - {{(POS_W-1){1'b0}}, neg_q};
  assign acc_x10  = {acc_q[MAG_W-4:0], 3'b000} + {acc_q[MAG_W-2:0], 1'b0};

  always_comb begin
    acc_n = acc_q;
    neg_n = neg_q;
    err_n = err_q;
    if (!err_q) begin
      if (is_minus) begin
        neg_n = 1'b1;
      end else if (!is_digit) begin
        err_n = 1'b1;
      end else if (digits >= MAX_DIGITS) begin
        err_n = 1'b1;
      end else begin
        acc_n = acc_x10 + {{(MAG_W-DIGIT_W){1'b0}}, digit};
      end
    end
    pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
  end

  always_comb begin
    acc_d = acc_q;
    neg_d = neg_q;
    err_d = err_q;
    pos_d = pos_q;
    if (fire) begin
      if (last_i) begin
        acc_d = '0;
        neg_d = 1'b0;
        err_d = 1'b0;
        pos_d = '0;
      end else begin
        acc_d = acc_n;
        neg_d = neg_n;
        err_d = err_n;
        pos_d = pos_n;
      end
    end
  end

  always_comb begin
    fld_valid_d = fld_valid_q && !fld_ready_i;
    fld_d       = fld_q;
    if (fire && last_i) begin
      fld_valid_d = 1'b1;
      fld_d.mag   = acc_n;
      fld_d.neg   = neg_n;
      fld_d.err   = err_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      neg_q       <= 1'b0;
      err_q       <= 1'b0;
      pos_q       <= '0;
      fld_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      err_q       <= err_d;
      pos_q       <= pos_d;
      fld_valid_q <= fld_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fld_q <= fld_d;
  end

  assign fld_valid_o = fld_valid_q;
  assign fld_o       = fld_q;

endmodule

@@ hw/rtl/fwdp_range_check.sv @@
// applies the sign, checks the value window and holds the result register
// depends on fwdp_pkg
`timescale 1ns / 1ps

module fwdp_range_check (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                fld_valid_i,
  output logic                                fld_ready_o,
  input  fwdp_pkg::field_t                    fld_i,
  input  logic signed [fwdp_pkg::VALUE_W-1:0] min_value_i,
  input  logic signed [fwdp_pkg::VALUE_W-1:0] max_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [fwdp_pkg::VALUE_W-1:0]        value_o,
  output logic                                parse_error_o
);
  import fwdp_pkg::*;

  logic [VALUE_W-1:0]        mag_ext;
  logic signed [VALUE_W-1:0] val;
  logic                      err, fire;
  logic                      out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]        value_q, value_d;
  logic                      perr_q, perr_d;

  assign fld_ready_o = !out_valid_q || out_ready_i;
  assign fire        = fld_valid_i && fld_ready_o;

  assign mag_ext = {1'b0, fld_i.mag};
  assign val     = fld_i.neg ? $signed(-mag_ext) : $signed(mag_ext);
  assign err     = fld_i.err || (val < min_value_i) || (val > max_value_i);

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    perr_d      = perr_q;
    if (fire) begin
      out_valid_d = 1'b1;
      value_d     = err ? '0 : val;
      perr_d      = err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    perr_q  <= perr_d;
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign parse_error_o = perr_q;

endmodule

@@ hw/rtl/fixed_width_decimal_parser.sv @@
// Parses a fixed width ASCII decimal field, one byte per transaction, into a signed
// value with an inclusive range check. A leading '-' makes the value negative; every
// other byte must be a digit, at most nine digits. One result per field, on the byte
// with tlast: tdata carries the value (0 on error), tuser the error flag. One byte
// is taken every cycle unless m_axis_tready holds results back; a result leaves through
// the input register, the accumulation stage and the range-check result register.
// Depends on fwdp_pkg, fwdp_digit_acc and fwdp_range_check.
`timescale 1ns / 1ps

module fixed_width_decimal_parser (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [fwdp_pkg::TDATA_IN_W-1:0]       s_axis_tdata,   // [7:0] char_code
  input  logic                                  s_axis_tlast,   // is_last
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [fwdp_pkg::TDATA_OUT_W-1:0]      m_axis_tdata,   // [30:0] value, [31] zero
  output logic                                  m_axis_tuser,   // parse_error
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [fwdp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [fwdp_pkg::VALUE_W-1:0]          cfg_data_i
);
  import fwdp_pkg::*;

  logic                      in_valid_q, in_valid_d;
  logic [CHAR_W-1:0]         in_char_q, in_char_d;
  logic                      in_last_q, in_last_d;
  logic                      acc_ready;
  logic                      fld_valid, fld_ready;
  field_t                    fld;
  logic signed [VALUE_W-1:0] min_value_q, min_value_d;
  logic signed [VALUE_W-1:0] max_value_q, max_value_d;
  logic [VALUE_W-1:0]        value;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    min_value_d = min_value_q;
    max_value_d = max_value_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MIN_VALUE: min_value_d = $signed(cfg_data_i);
        REG_MAX_VALUE: max_value_d = $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // input register
  assign s_axis_tready = !in_valid_q || acc_ready;

  always_comb begin
    in_valid_d = in_valid_q && !acc_ready;
    in_char_d  = in_char_q;
    in_last_d  = in_last_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
      in_char_d  = s_axis_tdata[CHAR_W-1:0];
      in_last_d  = s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      min_value_q <= MIN_VALUE_RESET;
      max_value_q <= MAX_VALUE_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      min_value_q <= min_value_d;
      max_value_q <= max_value_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_char_q <= in_char_d;
    in_last_q <= in_last_d;
  end

  fwdp_digit_acc u_digit_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_q),
    .ready_o     (acc_ready),
    .char_i      (in_char_q),
    .last_i      (in_last_q),
    .fld_valid_o (fld_valid),
    .fld_ready_i (fld_ready),
    .fld_o       (fld)
  );

  fwdp_range_check u_range_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fld_valid_i   (fld_valid),
    .fld_ready_o   (fld_ready),
    .fld_i         (fld),
    .min_value_i   (min_value_q),
    .max_value_i   (max_value_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .value_o       (value),
    .parse_error_o (m_axis_tuser)
  );

  assign m_axis_tdata = {{(TDATA_OUT_W-VALUE_W){1'b0}}, value};

endmodule
